/* src/cwwps_pkg.sv */
// Types, codes and shared arithmetic for the circle warp wipe pixel selector.
package cwwps_pkg;

    // Register and field widths
    localparam int DIM_W   = 13;
    localparam int PROG_W  = 16;
    localparam int COORD_W = 12;
    localparam int CFG_W   = 16;
    localparam int ROOT_W  = 13;
    localparam int REM_W   = 14;
    localparam int RAD2_W  = 26;

    localparam int COORD_RANGE_DEFAULT = 4096;

    // Configuration register indexes
    localparam logic [1:0] CFG_SCREEN_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_SCREEN_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_PROGRESS      = 2'd2;
    localparam logic [1:0] CFG_PROGRESS_MAX  = 2'd3;

    // Source picture codes
    localparam logic [1:0] SRC_START = 2'd0;
    localparam logic [1:0] SRC_END   = 2'd1;
    localparam logic [1:0] SRC_KEEP  = 2'd2;

    typedef struct packed {
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
    } pixel_t;

    typedef struct packed {
        logic [1:0]         source;
        logic [COORD_W-1:0] source_column;
    } result_t;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } root_state_t;

    // One digit of an exact square root: bring down two bits, try the next root bit
    function automatic root_state_t sqrt_step(input root_state_t cur, input logic [1:0] pair);
        logic [REM_W+1:0] trial_rem;
        logic [REM_W+1:0] trial_sub;
        root_state_t      nxt;
        trial_rem = {cur.rem, pair};
        trial_sub = {1'b0, cur.root, 2'b01};
        if (trial_rem >= trial_sub)
        begin
            nxt.rem  = REM_W'(trial_rem - trial_sub);
            nxt.root = {cur.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            nxt.rem  = trial_rem[REM_W-1:0];
            nxt.root = {cur.root[ROOT_W-2:0], 1'b0};
        end
        return nxt;
    endfunction

endpackage

/* src/circle_warp_wipe_pixel_select.sv */
// Top level of the circle warp wipe pixel selector: radius sequencer and pixel pipeline.
//
// Takes one pixel beat per clock while pix_stall is low and returns one result beat per
// pixel. Each pixel passes through a 19-stage pipeline: capture, row distance, its square,
// chord squared, 13 square root stages that resolve one root bit each, rounding and run
// select. After reset and after every configuration write a sequencer rebuilds the circle
// radius (centre, exact square root of the corner distance, multiply and 29-step restoring
// divide); pixel input is stalled while it runs. Write configuration only while no pixel is
// in flight.
module circle_warp_wipe_pixel_select
    import cwwps_pkg::*;
#(
    parameter int COORD_RANGE = COORD_RANGE_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [CFG_W-1:0]   cfg_data,
    input  logic               pix_valid,
    output logic               pix_stall,
    input  pixel_t             pix,
    output logic               res_valid,
    input  logic               res_stall,
    output result_t            res
);

    localparam int           SQ_STAGES = ROOT_W;
    localparam int           DIV_STEPS = PROG_W + ROOT_W;
    localparam logic [16:0]  RANGE_LIM = 17'(COORD_RANGE);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CENTRE = 3'd1;
    localparam logic [2:0] ST_SUMA   = 3'd2;
    localparam logic [2:0] ST_SUMB   = 3'd3;
    localparam logic [2:0] ST_ROOT   = 3'd4;
    localparam logic [2:0] ST_MUL    = 3'd5;
    localparam logic [2:0] ST_DIV    = 3'd6;
    localparam logic [2:0] ST_RSQ    = 3'd7;

    typedef struct packed {
        logic               skip;
        logic [COORD_W-1:0] column;
        logic [RAD2_W-1:0]  x;
        root_state_t        rs;
    } sq_stage_t;

    // Configuration registers
    logic [DIM_W-1:0]  width_reg, height_reg;
    logic [PROG_W-1:0] progress_reg, progress_max_reg;

    // Derived geometry
    logic [COORD_W-1:0] cx_reg, cy_reg;
    logic [DIM_W-1:0]   h_reg;
    logic [RAD2_W-1:0]  rsq_reg;

    // Sequencer
    logic [2:0]            state_reg;
    logic [4:0]            cnt_reg;
    logic [RAD2_W-1:0]     acc_reg;
    root_state_t           seq_rs_reg;
    logic [DIV_STEPS-1:0]  num_reg;
    logic [PROG_W:0]       drem_reg;
    logic                  busy;

    logic [DIM_W-1:0]  w_sat, h_sat;
    logic [PROG_W-1:0] div_d, div_c;
    logic [PROG_W:0]   div_t;
    logic              div_bit;
    root_state_t       seq_rs_next;

    always_comb
    begin
        w_sat = ({4'b0, width_reg} > RANGE_LIM) ? RANGE_LIM[DIM_W-1:0] : width_reg;
        h_sat = ({4'b0, height_reg} > RANGE_LIM) ? RANGE_LIM[DIM_W-1:0] : height_reg;
        div_d = (progress_max_reg == '0) ? PROG_W'(1) : progress_max_reg;
        div_c = (progress_reg > div_d) ? div_d : progress_reg;
        div_t = {drem_reg[PROG_W-1:0], num_reg[DIV_STEPS-1]};
        div_bit = (div_t >= {1'b0, div_d});
        seq_rs_next = sqrt_step(seq_rs_reg, acc_reg[RAD2_W-1:RAD2_W-2]);
        busy = (state_reg != ST_IDLE);
    end

    // Hold configuration; any write restarts the radius sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg        <= DIM_W'(640);
            height_reg       <= DIM_W'(480);
            progress_reg     <= '0;
            progress_max_reg <= PROG_W'(1);
            state_reg        <= ST_CENTRE;
            cnt_reg          <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_SCREEN_WIDTH:  width_reg        <= cfg_data[DIM_W-1:0];
                CFG_SCREEN_HEIGHT: height_reg       <= cfg_data[DIM_W-1:0];
                CFG_PROGRESS:      progress_reg     <= cfg_data;
                CFG_PROGRESS_MAX:  progress_max_reg <= cfg_data;
                default:           ;
            endcase
            state_reg <= ST_CENTRE;
            cnt_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:   state_reg <= ST_IDLE;
                ST_CENTRE: state_reg <= ST_SUMA;
                ST_SUMA:   state_reg <= ST_SUMB;
                ST_SUMB:
                begin
                    state_reg <= ST_ROOT;
                    cnt_reg   <= '0;
                end
                ST_ROOT:
                begin
                    if (cnt_reg == 5'(SQ_STAGES - 1))
                    begin
                        state_reg <= ST_MUL;
                        cnt_reg   <= '0;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 5'd1;
                    end
                end
                ST_MUL:
                begin
                    state_reg <= ST_DIV;
                    cnt_reg   <= '0;
                end
                ST_DIV:
                begin
                    if (cnt_reg == 5'(DIV_STEPS - 1))
                    begin
                        state_reg <= ST_RSQ;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 5'd1;
                    end
                end
                ST_RSQ:    state_reg <= ST_IDLE;
                default:   state_reg <= ST_IDLE;
            endcase
        end
    end

    // Sequencer datapath: centre, corner distance root, radius divide, radius squared
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_CENTRE:
            begin
                cx_reg <= w_sat[DIM_W-1:1];
                cy_reg <= h_sat[DIM_W-1:1];
                h_reg  <= h_sat;
            end
            ST_SUMA:
            begin
                acc_reg <= RAD2_W'(cx_reg * cx_reg);
            end
            ST_SUMB:
            begin
                acc_reg    <= acc_reg + RAD2_W'(cy_reg * cy_reg);
                seq_rs_reg <= '0;
            end
            ST_ROOT:
            begin
                seq_rs_reg <= seq_rs_next;
                acc_reg    <= {acc_reg[RAD2_W-3:0], 2'b00};
            end
            ST_MUL:
            begin
                num_reg  <= DIV_STEPS'(div_c * (seq_rs_reg.root + ROOT_W'(1)));
                drem_reg <= '0;
            end
            ST_DIV:
            begin
                drem_reg <= div_bit ? (div_t - {1'b0, div_d}) : div_t;
                num_reg  <= {num_reg[DIV_STEPS-2:0], div_bit};
            end
            ST_RSQ:
            begin
                rsq_reg <= RAD2_W'(num_reg[ROOT_W-1:0] * num_reg[ROOT_W-1:0]);
            end
            default: ;
        endcase
    end

    // Pixel pipeline registers
    logic                a_v_reg, b_v_reg, c_v_reg, e_v_reg, f_v_reg;
    pixel_t              a_reg;
    logic                b_skip_reg, c_skip_reg, e_skip_reg;
    logic [COORD_W-1:0]  b_col_reg, c_col_reg, e_col_reg;
    logic [COORD_W-1:0]  b_dy_reg;
    logic [2*COORD_W-1:0] c_yy_reg;
    logic [COORD_W-1:0]  e_hw_reg;
    result_t             f_reg;
    logic                sq_v_reg [0:SQ_STAGES];
    sq_stage_t           sq_reg   [0:SQ_STAGES];

    logic adv_a, adv_b, adv_c, adv_e, adv_f;
    logic adv_sq [0:SQ_STAGES];

    // Advance a stage when it is empty or its successor advances
    always_comb
    begin
        adv_f = !f_v_reg || !res_stall;
        adv_e = !e_v_reg || adv_f;
        adv_sq[SQ_STAGES] = !sq_v_reg[SQ_STAGES] || adv_e;
        for (int i = SQ_STAGES - 1; i >= 0; i--)
        begin
            adv_sq[i] = !sq_v_reg[i] || adv_sq[i+1];
        end
        adv_c = !c_v_reg || adv_sq[0];
        adv_b = !b_v_reg || adv_c;
        adv_a = !a_v_reg || adv_b;
    end

    assign pix_stall = busy || !adv_a;

    // Valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
            e_v_reg <= 1'b0;
            f_v_reg <= 1'b0;
            for (int i = 0; i <= SQ_STAGES; i++)
            begin
                sq_v_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (adv_a) a_v_reg <= pix_valid && !busy;
            if (adv_b) b_v_reg <= a_v_reg;
            if (adv_c) c_v_reg <= b_v_reg;
            if (adv_sq[0]) sq_v_reg[0] <= c_v_reg;
            for (int i = 1; i <= SQ_STAGES; i++)
            begin
                if (adv_sq[i]) sq_v_reg[i] <= sq_v_reg[i-1];
            end
            if (adv_e) e_v_reg <= sq_v_reg[SQ_STAGES];
            if (adv_f) f_v_reg <= e_v_reg;
        end
    end

    // Front stages: capture, row distance, its square, chord squared
    always_ff @(posedge clk)
    begin
        if (adv_a)
        begin
            a_reg <= pix;
        end
        if (adv_b)
        begin
            b_skip_reg <= ({1'b0, a_reg.row} >= h_reg) ||
                          ({1'b0, a_reg.column} >= {cx_reg, 1'b0});
            b_col_reg  <= a_reg.column;
            b_dy_reg   <= (a_reg.row >= cy_reg) ? (a_reg.row - cy_reg) : (cy_reg - a_reg.row);
        end
        if (adv_c)
        begin
            c_skip_reg <= b_skip_reg;
            c_col_reg  <= b_col_reg;
            c_yy_reg   <= b_dy_reg * b_dy_reg;
        end
        if (adv_sq[0])
        begin
            sq_reg[0].skip   <= c_skip_reg;
            sq_reg[0].column <= c_col_reg;
            sq_reg[0].x      <= (rsq_reg > RAD2_W'(c_yy_reg)) ?
                                (rsq_reg - RAD2_W'(c_yy_reg)) : '0;
            sq_reg[0].rs     <= '0;
        end
    end

    // Square root stages: one root bit each
    for (genvar g = 1; g <= SQ_STAGES; g++)
    begin : g_sqrt
        always_ff @(posedge clk)
        begin
            if (adv_sq[g])
            begin
                sq_reg[g].skip   <= sq_reg[g-1].skip;
                sq_reg[g].column <= sq_reg[g-1].column;
                sq_reg[g].x      <= {sq_reg[g-1].x[RAD2_W-3:0], 2'b00};
                sq_reg[g].rs     <= sqrt_step(sq_reg[g-1].rs,
                                              sq_reg[g-1].x[RAD2_W-1:RAD2_W-2]);
            end
        end
    end

    // Round the half-width, clamp to the centre column, then pick the run
    logic [ROOT_W:0]     hw_round;
    logic [COORD_W-1:0]  left_end;
    logic [COORD_W:0]    right_start;
    logic [COORD_W-1:0]  hw_twice;

    always_comb
    begin
        hw_round = {1'b0, sq_reg[SQ_STAGES].rs.root} +
                   ((sq_reg[SQ_STAGES].rs.rem > {1'b0, sq_reg[SQ_STAGES].rs.root}) ?
                    (ROOT_W+1)'(1) : '0);
        left_end    = cx_reg - e_hw_reg;
        right_start = {1'b0, cx_reg} + {1'b0, e_hw_reg};
        hw_twice    = {e_hw_reg[COORD_W-2:0], 1'b0};
    end

    always_ff @(posedge clk)
    begin
        if (adv_e)
        begin
            e_skip_reg <= sq_reg[SQ_STAGES].skip;
            e_col_reg  <= sq_reg[SQ_STAGES].column;
            e_hw_reg   <= (hw_round > {2'b0, cx_reg}) ? cx_reg : hw_round[COORD_W-1:0];
        end
        if (adv_f)
        begin
            priority if (e_skip_reg)
            begin
                f_reg.source        <= SRC_KEEP;
                f_reg.source_column <= '0;
            end
            else if (e_col_reg < left_end)
            begin
                f_reg.source        <= SRC_START;
                f_reg.source_column <= e_col_reg;
            end
            else if ({1'b0, e_col_reg} < right_start)
            begin
                f_reg.source        <= SRC_END;
                f_reg.source_column <= e_col_reg - left_end;
            end
            else
            begin
                f_reg.source        <= SRC_START;
                f_reg.source_column <= e_col_reg - hw_twice;
            end
        end
    end

    assign res_valid = f_v_reg;
    assign res       = f_reg;

endmodule

/* tb/cwwps_checker.sv */
// Checker for the circle warp wipe pixel selector: predicts each pixel's source and compares.
`timescale 1ns / 1ps
module cwwps_checker
    import cwwps_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write,
    input  logic [1:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             pix_valid,
    input  logic             pix_stall,
    input  pixel_t           pix,
    input  logic             res_valid,
    input  logic             res_stall,
    input  result_t          res,
    output int               fail_count,
    output int               pending,
    output int               checked
);

    localparam int COORD_LIMIT = 4096;

    // Shadow copy of the configuration registers
    logic [12:0] shadow_width;
    logic [12:0] shadow_height;
    logic [15:0] shadow_progress;
    logic [15:0] shadow_progress_max;

    result_t expected_sources[$];

    // Exact floor square root by restoring digit method
    function automatic longint unsigned floor_root(input longint unsigned v);
        longint unsigned acc;
        longint unsigned bitv;
        acc  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= acc + bitv)
            begin
                v   = v - (acc + bitv);
                acc = (acc >> 1) + bitv;
            end
            else
                acc = acc >> 1;
            bitv = bitv >> 2;
        end
        return acc;
    endfunction

    // Work out which picture and column feed this pixel
    function automatic result_t pick_source(input pixel_t p);
        longint unsigned w, h, cx, cy, den, cur, rmax, rad, dy, yy, rsq, hw, s, x2, left_end;
        result_t o;
        w  = (shadow_width > COORD_LIMIT) ? COORD_LIMIT : shadow_width;
        h  = (shadow_height > COORD_LIMIT) ? COORD_LIMIT : shadow_height;
        cx = w / 2;
        cy = h / 2;
        if (p.row >= h || p.column >= 2 * cx)
        begin
            o.source        = SRC_KEEP;
            o.source_column = '0;
            return o;
        end
        den  = (shadow_progress_max < 1) ? 1 : shadow_progress_max;
        cur  = (shadow_progress > den) ? den : shadow_progress;
        rmax = floor_root(cx * cx + cy * cy) + 1;
        rad  = (cur * rmax) / den;
        dy   = (p.row >= cy) ? p.row - cy : cy - p.row;
        yy   = dy * dy;
        rsq  = rad * rad;
        if (rsq <= yy)
            hw = 0;
        else
        begin
            x2 = rsq - yy;
            s  = floor_root(x2);
            if (x2 > s * s + s)
                s++;
            hw = (s > cx) ? cx : s;
        end
        left_end = cx - hw;
        if (p.column < left_end)
        begin
            o.source        = SRC_START;
            o.source_column = p.column;
        end
        else if (p.column < cx + hw)
        begin
            o.source        = SRC_END;
            o.source_column = COORD_W'(p.column - left_end);
        end
        else
        begin
            o.source        = SRC_START;
            o.source_column = COORD_W'(p.column - 2 * hw);
        end
        return o;
    endfunction

    assign pending = expected_sources.size();

    // Track writes, predict accepted pixels, compare accepted results
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            shadow_width        <= 13'd640;
            shadow_height       <= 13'd480;
            shadow_progress     <= 16'd0;
            shadow_progress_max <= 16'd1;
            fail_count          <= 0;
            checked             <= 0;
            expected_sources.delete();
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_SCREEN_WIDTH:  shadow_width        <= cfg_data[12:0];
                    CFG_SCREEN_HEIGHT: shadow_height       <= cfg_data[12:0];
                    CFG_PROGRESS:      shadow_progress     <= cfg_data;
                    CFG_PROGRESS_MAX:  shadow_progress_max <= cfg_data;
                    default: ;
                endcase
            end
            if (pix_valid && !pix_stall)
                expected_sources.push_back(pick_source(pix));
            if (res_valid && !res_stall)
            begin
                checked <= checked + 1;
                if (expected_sources.size() == 0)
                begin
                    $error("result beat with nothing expected: source %0d column %0d",
                           res.source, res.source_column);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_sources.pop_front();
                    if (res.source !== want.source)
                    begin
                        $error("source: expected %0d actual %0d", want.source, res.source);
                        fail_count <= fail_count + 1;
                    end
                    else if (res.source_column !== want.source_column)
                    begin
                        $error("source_column: expected %0d actual %0d",
                               want.source_column, res.source_column);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

/* tb/tb_top.sv */
// Stimulus and verdict for the circle warp wipe pixel selector.
`timescale 1ns / 1ps
module tb_top;
    import cwwps_pkg::*;

    localparam longint CYCLE_LIMIT  = 2000000;
    localparam int     HOLD_OFF_LEN = 200;

    logic             clk;
    logic             rst_n;
    logic             cfg_write;
    logic [1:0]       cfg_index;
    logic [CFG_W-1:0] cfg_data;
    logic             pix_valid;
    logic             pix_stall;
    pixel_t           pix;
    logic             res_valid;
    logic             res_stall;
    result_t          res;
    int               fail_count;
    int               pending;
    int               checked;

    int     send_idle_pct;
    int     recv_stall_pct;
    int     hold_off_cycles;
    logic   hold_off_go;
    logic   hold_off_done;
    longint cycle_count = 0;
    int     pixels_sent;
    int     settings_used;
    logic [12:0] cur_w;
    logic [12:0] cur_h;

    circle_warp_wipe_pixel_select u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix       (pix),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    cwwps_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .pix_valid  (pix_valid),
        .pix_stall  (pix_stall),
        .pix        (pix),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res        (res),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    // Clock
    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Receiver: random stall, or one long hold-off counted here once asked for
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_stall       <= 1'b0;
            hold_off_cycles <= 0;
            hold_off_done   <= 1'b0;
        end
        else if (hold_off_go && !hold_off_done)
        begin
            res_stall       <= 1'b1;
            hold_off_cycles <= hold_off_cycles + 1;
            if (hold_off_cycles == HOLD_OFF_LEN - 1)
                hold_off_done <= 1'b1;
        end
        else
            res_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Write one register; the caller has drained the pixel pipeline first
    task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        if (idx == CFG_SCREEN_WIDTH)
            cur_w = val[12:0];
        if (idx == CFG_SCREEN_HEIGHT)
            cur_h = val[12:0];
    endtask

    // Drop the pixel offer, drain all results, then let the pipeline settle
    task automatic drain;
        pix_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic load_setting(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                                input logic [CFG_W-1:0] pr, input logic [CFG_W-1:0] pm);
        drain();
        write_reg(CFG_SCREEN_WIDTH, w);
        write_reg(CFG_SCREEN_HEIGHT, h);
        write_reg(CFG_PROGRESS, pr);
        write_reg(CFG_PROGRESS_MAX, pm);
        cfg_write <= 1'b0;
        settings_used++;
    endtask

    // Offer one pixel beat and hold it until taken
    task automatic send_pixel(input logic [11:0] col, input logic [11:0] row);
        while ($urandom_range(99) < send_idle_pct)
        begin
            pix_valid <= 1'b0;
            @(posedge clk);
        end
        pix_valid <= 1'b1;
        pix.column <= col;
        pix.row    <= row;
        @(posedge clk);
        while (pix_stall)
            @(posedge clk);
        pixels_sent++;
    endtask

    // Mostly pixels inside the screen, some anywhere
    task automatic send_random_pixel;
        logic [11:0] c, r;
        if ($urandom_range(9) < 8 && cur_w > 1 && cur_h > 0)
        begin
            c = $urandom_range((cur_w > 4096 ? 4096 : cur_w) - 1);
            r = $urandom_range((cur_h > 4096 ? 4096 : cur_h) - 1);
        end
        else
        begin
            c = $urandom;
            r = $urandom;
        end
        send_pixel(c, r);
    endtask

    task automatic set_idling(input int phase);
        case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
            default: begin send_idle_pct = 9; recv_stall_pct = 9; end
        endcase
    endtask

    initial
    begin
        int p;
        int k;
        int pm;
        rst_n           = 1'b0;
        cfg_write       = 1'b0;
        cfg_index       = CFG_SCREEN_WIDTH;
        cfg_data        = '0;
        pix_valid       = 1'b0;
        pix             = '0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        hold_off_go     = 1'b0;
        pixels_sent     = 0;
        settings_used   = 0;
        cur_w           = 13'd640;
        cur_h           = 13'd480;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        repeat (60) @(posedge clk);

        // Directed: reset settings, zero progress, edges of the fields
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd639, 12'd479);
        send_pixel(12'd640, 12'd0);
        send_pixel(12'd0, 12'd480);
        send_pixel(12'hFFF, 12'hFFF);
        // Half progress, odd width: last column unwritten
        load_setting(16'd641, 16'd481, 16'd1, 16'd2);
        send_pixel(12'd640, 12'd240);
        send_pixel(12'd320, 12'd240);
        send_pixel(12'd100, 12'd240);
        send_pixel(12'd600, 12'd240);
        send_pixel(12'd320, 12'd0);
        // Full progress, progress above maximum, zero maximum
        load_setting(16'd4096, 16'd4096, 16'd9, 16'd0);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd2048, 12'd2048);
        // Oversized screen saturates
        load_setting(16'h1FFF, 16'h1FFF, 16'hFFFF, 16'hFFFF);
        send_pixel(12'd4095, 12'd0);
        send_pixel(12'd2047, 12'd2048);
        // Zero-size, one-pixel and two-by-two screens
        load_setting(16'd0, 16'd0, 16'd3, 16'd7);
        send_pixel(12'd0, 12'd0);
        load_setting(16'd1, 16'd1, 16'd1, 16'd1);
        send_pixel(12'd0, 12'd0);
        load_setting(16'd2, 16'd2, 16'd1, 16'd1);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd1, 12'd0);

        // Long hold-off so the pipeline fills and stalls its input
        load_setting(16'd64, 16'd48, 16'd5, 16'd9);
        hold_off_go = 1'b1;
        for (k = 0; k < 60; k++)
            send_random_pixel();

        // Random phases: mostly small screens, a few large
        for (p = 0; p < 40; p++)
        begin
            pm = $urandom_range(3) == 0 ? $urandom_range(65535) : $urandom_range(16);
            if (p % 8 == 7)
                load_setting($urandom_range(8191), $urandom_range(8191), $urandom, pm);
            else
                load_setting($urandom_range(1, 200), $urandom_range(1, 200),
                             $urandom_range(pm + 2), pm);
            set_idling(p);
            for (k = 0; k < 37; k++)
                send_random_pixel();
        end

        drain();
        $display("Sent %0d pixels over %0d register settings; %0d results checked.",
                 pixels_sent, settings_used, checked);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* files.f */
src/cwwps_pkg.sv
src/circle_warp_wipe_pixel_select.sv
tb/cwwps_checker.sv
tb/tb_top.sv
